@@ src/drs_pkg.sv @@
// Shared types and codes for the disk request scheduler.
package drs_pkg;

    typedef struct packed {
        logic        batch;
        logic [15:0] id;
        logic [15:0] track;
    } t_entry;

    localparam logic [2:0] POL_FIFO  = 3'd0;
    localparam logic [2:0] POL_SSTF  = 3'd1;
    localparam logic [2:0] POL_LOOK  = 3'd2;
    localparam logic [2:0] POL_CLOOK = 3'd3;
    localparam logic [2:0] POL_FLOOK = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

endpackage

@@ src/disk_request_scheduler.sv @@
// Disk request scheduler top level: queue control, policy scan and removal.
//
// Input channel: i_valid/o_stall with i_mode, i_track, i_request_id,
// i_head_track, i_head_direction. A beat is taken when i_valid is high and
// o_stall is low. Output channel: o_valid/i_stall with one result beat per
// input beat. The user must write the policy register on i_cfg_valid
// (o_cfg_ready is always high) only while the block is idle; the block
// itself does not enforce this. An add, or any beat that ends in an
// error status, goes from idle straight to the done state. A dispatch
// scans every pending entry through the memory read port, one a cycle,
// then reads the chosen entry and shifts the entries behind it down by
// one, again one a cycle, a pace set by the single read port of the
// entry memory.
// One beat is in work at a time; o_stall is high from acceptance until
// the result is loaded into the output register.
// A result that the receiver stalls stays in the output register; the
// next result waits behind it.
// Reset empties the queue, selects the first batch and sets policy fifo.
// No clearing pass is needed: only entries below the count are read.
module disk_request_scheduler #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [15:0]        i_track,
    input  logic [15:0]        i_request_id,
    input  logic [15:0]        i_head_track,
    input  logic signed [1:0]  i_head_direction,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [15:0]        o_granted_id,
    output logic [15:0]        o_granted_track,
    output logic signed [1:0]  o_new_direction,
    output logic               o_all_empty
);
    import drs_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_GRANT = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int T_FU = 0;
    localparam int T_FD = 1;
    localparam int T_AU = 2;
    localparam int T_AD = 3;
    localparam int T_SS = 4;
    localparam int T_MN = 5;
    localparam int NT   = 6;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_policy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_act, n_act;
    logic [CW-1:0] r_idx, n_idx;
    logic [15:0]   r_head;
    logic [1:0]    r_dir;
    logic [AW-1:0] r_pos, n_pos;
    logic [1:0]    r_st, n_st;
    logic [15:0]   r_gid, n_gid;
    logic [15:0]   r_gtrk, n_gtrk;
    logic [1:0]    r_ndir, n_ndir;

    logic          r_tf [NT];
    logic [15:0]   r_td [NT];
    logic [AW-1:0] r_tp [NT];
    logic          cv   [NT];
    logic [15:0]   cd   [NT];

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;

    logic          ge, le, act, up_first, any_act;
    logic [15:0]   du, dd;
    logic [AW-1:0] sel_pos;
    logic [1:0]    sel_dir;
    logic          sel_flip;

    drs_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);

    assign ge  = (rdata.track >= r_head);
    assign le  = (rdata.track <= r_head);
    assign du  = rdata.track - r_head;
    assign dd  = r_head - rdata.track;
    assign act = (rdata.batch == r_act);

    always_comb begin
        cv[T_FU] = act && ge;  cd[T_FU] = du;
        cv[T_FD] = act && le;  cd[T_FD] = dd;
        cv[T_AU] = ge;         cd[T_AU] = du;
        cv[T_AD] = le;         cd[T_AD] = dd;
        cv[T_SS] = 1'b1;       cd[T_SS] = ge ? du : dd;
        cv[T_MN] = 1'b1;       cd[T_MN] = rdata.track;
    end

    assign up_first = (r_dir != DIR_DOWN);
    assign any_act  = r_tf[T_FU] || r_tf[T_FD];

    always_comb begin
        sel_pos  = '0;
        sel_dir  = r_dir;
        sel_flip = 1'b0;
        unique case (r_policy)
            POL_SSTF: begin
                sel_pos = r_tp[T_SS];
            end
            POL_LOOK, POL_FLOOK: begin
                if (r_policy == POL_FLOOK && any_act) begin
                    if (up_first ? r_tf[T_FU] : !r_tf[T_FD]) begin
                        sel_pos = r_tp[T_FU];
                        sel_dir = DIR_UP;
                    end else begin
                        sel_pos = r_tp[T_FD];
                        sel_dir = DIR_DOWN;
                    end
                end else begin
                    sel_flip = (r_policy == POL_FLOOK);
                    if (up_first ? r_tf[T_AU] : !r_tf[T_AD]) begin
                        sel_pos = r_tp[T_AU];
                        sel_dir = DIR_UP;
                    end else begin
                        sel_pos = r_tp[T_AD];
                        sel_dir = DIR_DOWN;
                    end
                end
            end
            POL_CLOOK: begin
                sel_pos = r_tf[T_AU] ? r_tp[T_AU] : r_tp[T_MN];
            end
            default: begin
                sel_pos = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_act   = r_act;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_st    = r_st;
        n_gid   = r_gid;
        n_gtrk  = r_gtrk;
        n_ndir  = r_ndir;
        we      = 1'b0;
        waddr   = r_cnt[AW-1:0];
        wdata   = '{batch: ~r_act, id: i_request_id, track: i_track};
        raddr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_st   = ST_OK;
                    n_gid  = '0;
                    n_gtrk = '0;
                    n_ndir = i_head_direction;
                    n_idx  = '0;
                    if (!i_mode) begin
                        n_state = S_DONE;
                        if (r_cnt >= FULL_CNT) begin
                            n_st = ST_FULL;
                        end else begin
                            we    = 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (r_cnt == '0) begin
                        n_st    = ST_EMPTY;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx + 1'b1 < r_cnt) begin
                    n_idx = r_idx + 1'b1;
                    raddr = n_idx[AW-1:0];
                end else begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                raddr  = sel_pos;
                n_pos  = sel_pos;
                n_ndir = sel_dir;
                if (sel_flip) begin
                    n_act = ~r_act;
                end
                n_state = S_GRANT;
            end
            S_GRANT: begin
                n_gid   = rdata.id;
                n_gtrk  = rdata.track;
                n_idx   = CW'(r_pos) + 1'b1;
                raddr   = n_idx[AW-1:0];
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_idx < r_cnt) begin
                    we    = 1'b1;
                    waddr = AW'(r_idx - 1'b1);
                    wdata = rdata;
                    n_idx = r_idx + 1'b1;
                    raddr = n_idx[AW-1:0];
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!o_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_act    <= 1'b0;
            r_policy <= POL_FIFO;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_act   <= n_act;
            if (i_cfg_valid) begin
                r_policy <= i_cfg_data;
            end
            if (r_state == S_DONE && (!o_valid || !i_stall)) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_st   <= n_st;
        r_gid  <= n_gid;
        r_gtrk <= n_gtrk;
        r_ndir <= n_ndir;
        if (r_state == S_IDLE) begin
            r_head <= i_head_track;
            r_dir  <= i_head_direction;
        end
        for (int k = 0; k < NT; k++) begin
            if (r_state == S_IDLE) begin
                r_tf[k] <= 1'b0;
            end else if (r_state == S_SCAN && cv[k] && (!r_tf[k] || cd[k] < r_td[k])) begin
                r_tf[k] <= 1'b1;
                r_td[k] <= cd[k];
                r_tp[k] <= r_idx[AW-1:0];
            end
        end
        if (r_state == S_DONE && (!o_valid || !i_stall)) begin
            o_status        <= r_st;
            o_granted_id    <= r_gid;
            o_granted_track <= r_gtrk;
            o_new_direction <= r_ndir;
            o_all_empty     <= (r_cnt == '0);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("pending count beyond depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_cnt))
        else $error("scan index beyond pending count");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result beat without finished item");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_state != S_SCAN) || $past(r_state == S_IDLE)
            || $past(r_state == S_SCAN))
        else $error("scan entered from wrong state");

endmodule

@@ src/drs_mem.sv @@
// Single-port-write, registered-read entry memory for the request queue.
module drs_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  drs_pkg::t_entry       i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output drs_pkg::t_entry       o_rdata
);
    import drs_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the disk request scheduler: directed and random traffic checked against a scoreboard model.
module tb_top;
    import drs_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] gid;
        logic [15:0] gtrk;
        logic [1:0]  ndir;
        logic        empty;
    } t_result;

    class sched_scoreboard;
        logic [15:0] trk_q[64];
        logic [15:0] id_q[64];
        logic        bat_q[64];
        int          count;
        logic        active;
        logic [2:0]  policy;
        t_result     pending_res[$];

        function void clear();
            count = 0;
            active = 1'b0;
            policy = POL_FIFO;
            pending_res.delete();
        endfunction

        function bit nearest(logic [15:0] head, bit up, bit use_b, output int pos);
            bit   found;
            int   best;
            int   d;
            found = 0;
            best = 0;
            pos = 0;
            for (int i = 0; i < count; i++) begin
                if (use_b && bat_q[i] != active) continue;
                if (up) begin
                    if (trk_q[i] < head) continue;
                    d = trk_q[i] - head;
                end else begin
                    if (trk_q[i] > head) continue;
                    d = head - trk_q[i];
                end
                if (!found || d < best) begin
                    found = 1;
                    best = d;
                    pos = i;
                end
            end
            return found;
        endfunction

        function void note(logic mode, logic [15:0] trk, logic [15:0] rid,
                           logic [15:0] head, logic [1:0] dir);
            t_result r;
            int      pos;
            int      best;
            int      d;
            bit      up;
            bit      any;
            r = '0;
            r.ndir = dir;
            pos = 0;
            if (mode == 1'b0) begin
                if (count >= 64) begin
                    r.status = ST_FULL;
                end else begin
                    trk_q[count] = trk;
                    id_q[count] = rid;
                    bat_q[count] = ~active;
                    count++;
                end
            end else if (count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                case (policy)
                    POL_SSTF: begin
                        best = 0;
                        for (int i = 0; i < count; i++) begin
                            d = (trk_q[i] > head) ? trk_q[i] - head : head - trk_q[i];
                            if (i == 0 || d < best) begin
                                best = d;
                                pos = i;
                            end
                        end
                    end
                    POL_LOOK, POL_FLOOK: begin
                        up = (dir != DIR_DOWN);
                        if (policy == POL_FLOOK) begin
                            any = 0;
                            for (int i = 0; i < count; i++)
                                if (bat_q[i] == active) any = 1;
                            if (!any) active = ~active;
                        end
                        if (nearest(head, up, policy == POL_FLOOK, pos)) begin
                            r.ndir = up ? DIR_UP : DIR_DOWN;
                        end else begin
                            void'(nearest(head, !up, policy == POL_FLOOK, pos));
                            r.ndir = up ? DIR_DOWN : DIR_UP;
                        end
                    end
                    POL_CLOOK: begin
                        if (!nearest(head, 1, 0, pos)) begin
                            best = 0;
                            for (int i = 0; i < count; i++) begin
                                if (i == 0 || trk_q[i] < best) begin
                                    best = trk_q[i];
                                    pos = i;
                                end
                            end
                        end
                    end
                    default: pos = 0;
                endcase
                r.gid = id_q[pos];
                r.gtrk = trk_q[pos];
                for (int i = pos; i + 1 < count; i++) begin
                    trk_q[i] = trk_q[i + 1];
                    id_q[i] = id_q[i + 1];
                    bat_q[i] = bat_q[i + 1];
                end
                count--;
            end
            r.empty = (count == 0);
            pending_res.insert(pending_res.size(), r);
        endfunction

        function bit check(t_result got, output string msg);
            t_result e;
            if (pending_res.size() == 0) begin
                msg = "result beat with nothing pending";
                return 0;
            end
            e = pending_res[0];
            pending_res.delete(0);
            if (got !== e) begin
                msg = $sformatf({"exp st=%0d id=%h trk=%h dir=%b emp=%b, ",
                                 "got st=%0d id=%h trk=%h dir=%b emp=%b"},
                                e.status, e.gid, e.gtrk, e.ndir, e.empty,
                                got.status, got.gid, got.gtrk, got.ndir, got.empty);
                return 0;
            end
            msg = "";
            return 1;
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_mode = 1'b0;
    logic [15:0]        i_track = '0;
    logic [15:0]        i_request_id = '0;
    logic [15:0]        i_head_track = '0;
    logic signed [1:0]  i_head_direction = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic [1:0]         o_status;
    logic [15:0]        o_granted_id;
    logic [15:0]        o_granted_track;
    logic signed [1:0]  o_new_direction;
    logic               o_all_empty;

    sched_scoreboard sb = new();
    int  errors = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    bit  long_hold = 0;
    bit  no_idle = 0;

    always #5 i_clk = ~i_clk;

    disk_request_scheduler dut (.*);

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic send(logic mode, logic [15:0] trk, logic [15:0] rid,
                        logic [15:0] head, logic [1:0] dir);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_track <= trk;
        i_request_id <= rid;
        i_head_track <= head;
        i_head_direction <= dir;
        do @(posedge i_clk); while (o_stall);
        sb.note(mode, trk, rid, head, dir);
        beats_in++;
    endtask

    task automatic set_policy(logic [2:0] p);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_res.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.policy = p;
    endtask

    function automatic logic [15:0] pick_track();
        return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    endfunction

    // receiver: check accepted beats, draw stall per item
    initial begin
        int    wait_n;
        string msg;
        t_result got;
        wait_n = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got = {o_status, o_granted_id, o_granted_track, o_new_direction, o_all_empty};
                if (!sb.check(got, msg)) report(msg);
                beats_out++;
                wait_n = no_idle ? 0 : $urandom_range(0, 11);
            end else if (wait_n > 0) begin
                wait_n--;
            end
            i_stall <= long_hold || (wait_n > 0);
        end
    end

    initial begin
        @(posedge i_rst_n);
        repeat (8000) @(posedge i_clk);
        long_hold = 1;
        repeat (3000) @(posedge i_clk);
        long_hold = 0;
    end

    initial begin
        repeat (2_000_000) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [2:0] plist[14];
        int p_add;
        plist = '{POL_FLOOK, POL_SSTF, POL_LOOK, POL_CLOOK, POL_FIFO,
                  POL_FLOOK, POL_LOOK, POL_CLOOK, POL_SSTF, 3'd7,
                  3'd5, 3'd6, POL_FLOOK, POL_LOOK};
        sb.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(1'b1, 16'h0000, 16'h0000, 16'hffff, 2'b10);
        send(1'b0, 16'h0000, 16'h0000, 16'h0000, 2'b00);
        send(1'b0, 16'hffff, 16'hffff, 16'hffff, 2'b01);
        send(1'b0, 16'h8000, 16'h1234, 16'h0000, 2'b11);
        send(1'b0, 16'h8000, 16'h5678, 16'h0000, 2'b10);
        send(1'b1, 16'h0000, 16'h0000, 16'h8000, 2'b11);
        send(1'b1, 16'hffff, 16'hffff, 16'h0000, 2'b01);
        set_policy(POL_LOOK);
        send(1'b0, 16'h0010, 16'h0001, 16'h0000, 2'b00);
        send(1'b1, 16'h0000, 16'h0000, 16'h0010, 2'b11);
        send(1'b1, 16'h0000, 16'h0000, 16'hffff, 2'b10);
        send(1'b1, 16'h0000, 16'h0000, 16'h0000, 2'b00);
        send(1'b1, 16'h0000, 16'h0000, 16'h0000, 2'b01);

        foreach (plist[k]) begin
            set_policy(plist[k]);
            no_idle = (k % 4 == 3);
            p_add = (k % 3 == 0) ? 85 : $urandom_range(35, 65);
            for (int n = 0; n < 145; n++) begin
                if (n == 100) p_add = 30;
                send(($urandom_range(1, 100) > p_add), pick_track(), 16'($urandom),
                     pick_track(), 2'($urandom));
            end
        end

        i_valid <= 1'b0;
        while (sb.pending_res.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d input beats, %0d results, all five policies and unused codes",
                 beats_in, beats_out);
        $display("including full store, empty dispatch, ties and a long output hold");
        if (errors == 0 && sb.pending_res.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
